### sv/ss_pkg.sv
// shared types and state codes for the selection sorter
`timescale 1ns / 1ps

package ss_pkg;

  localparam int VAL_W = 32;

  typedef struct packed {
    logic signed [VAL_W-1:0] sort_value;
    logic                    is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sorted_value;
    logic                    last_out;
    logic                    overflow;
  } out_item_t;

  typedef struct packed {
    logic vld;
    logic first;
  } scan_ctl_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_SWAP_A,
    S_SWAP_B,
    S_OUT_RD,
    S_OUT_CAP
  } state_t;

endpackage

### sv/ss_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps

module ss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/ss_min_unit.sv
// running minimum tracker for one selection pass
`timescale 1ns / 1ps

module ss_min_unit #(
  parameter int IDX_W = 3
) (
  input  logic                           clk,
  input  ss_pkg::scan_ctl_t              ctl,
  input  logic [IDX_W-1:0]               tag,
  input  logic signed [ss_pkg::VAL_W-1:0] data,
  output logic signed [ss_pkg::VAL_W-1:0] min_val,
  output logic [IDX_W-1:0]               min_idx,
  output logic signed [ss_pkg::VAL_W-1:0] start_val
);

  logic signed [ss_pkg::VAL_W-1:0] min_val_r, min_val_nxt;
  logic signed [ss_pkg::VAL_W-1:0] start_val_r, start_val_nxt;
  logic [IDX_W-1:0]                min_idx_r, min_idx_nxt;

  always_comb begin
    min_val_nxt   = min_val_r;
    min_idx_nxt   = min_idx_r;
    start_val_nxt = start_val_r;
    if (ctl.vld) begin
      if (ctl.first) begin
        min_val_nxt   = data;
        min_idx_nxt   = tag;
        start_val_nxt = data;
      end else if (data < min_val_r) begin
        min_val_nxt = data;
        min_idx_nxt = tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    min_val_r   <= min_val_nxt;
    min_idx_r   <= min_idx_nxt;
    start_val_r <= start_val_nxt;
  end

  assign min_val   = min_val_r;
  assign min_idx   = min_idx_r;
  assign start_val = start_val_r;

endmodule

### sv/selection_sorter.sv
// selection sorter top level: load, in-memory selection sort, sorted output
//
// usage: values arrive on the in_ channel, one per transfer, and the transfer
// with is_last set closes the set. up to MAX_ITEMS values are kept in a ram;
// further values are discarded and every result of that set flags overflow.
// while loading, in_stall is low and a transfer is taken whenever in_valid is
// high. after the closing transfer in_stall rises until the set has been
// sorted and its final result sits in the output register.
// in sorting, each pass streams the unsorted tail through the single ram read
// port into the minimum tracker, then writes the swap through the single
// write port in S_SWAP_A and S_SWAP_B. each result is read from the ram
// (S_OUT_RD), then loaded into the output register (S_OUT_CAP); the final
// one carries last_out.
// a stall on the out_ channel holds the output register and pauses the read
// sequence; the next set is accepted while the final result still waits.
// reset (rst_n low, synchronous) empties the set and the output register;
// ram contents are not cleared and are only read after being written.
`timescale 1ns / 1ps

module selection_sorter #(
  parameter int MAX_ITEMS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ss_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ss_pkg::out_item_t out_data
);

  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);

  ss_pkg::state_t    state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              dropped_r, dropped_nxt;
  logic [IDX_W-1:0]  start_r, start_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]  rd_tag_r, rd_tag_nxt;
  logic              out_vld_r, out_vld_nxt;
  ss_pkg::out_item_t out_data_r, out_data_nxt;

  logic                            ram_we, ram_re;
  logic [IDX_W-1:0]                ram_waddr, ram_raddr;
  logic [ss_pkg::VAL_W-1:0]        ram_wdata, ram_rdata;
  ss_pkg::scan_ctl_t               scan_ctl;
  logic signed [ss_pkg::VAL_W-1:0] min_val, start_val;
  logic [IDX_W-1:0]                min_idx;

  logic             in_xfer, out_free;
  logic [CNT_W-1:0] count_load, last_idx;
  logic             scan_end, more_pass, out_final;

  assign in_xfer    = in_valid && !in_stall;
  assign out_free   = !out_vld_r || !out_stall;
  assign count_load = (count_r < CNT_MAX) ? count_r + CNT_W'(1) : count_r;
  assign last_idx   = count_r - CNT_W'(1);
  assign scan_end   = CNT_W'(rd_idx_r) == last_idx;
  assign more_pass  = (CNT_W'(start_r) + CNT_W'(2)) < count_r;
  assign out_final  = (CNT_W'(out_idx_r) + CNT_W'(1)) == count_r;

  assign scan_ctl.vld   = rd_vld_r;
  assign scan_ctl.first = rd_tag_r == start_r;

  ss_ram #(
    .WIDTH(ss_pkg::VAL_W),
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ss_min_unit #(
    .IDX_W(IDX_W)
  ) u_min (
    .clk      (clk),
    .ctl      (scan_ctl),
    .tag      (rd_tag_r),
    .data     ($signed(ram_rdata)),
    .min_val  (min_val),
    .min_idx  (min_idx),
    .start_val(start_val)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ss_pkg::S_LOAD: begin
        if (in_xfer && in_data.is_last) begin
          state_nxt = (count_load >= CNT_W'(2)) ? ss_pkg::S_SCAN : ss_pkg::S_OUT_RD;
        end
      end
      ss_pkg::S_SCAN: begin
        if (scan_end) begin
          state_nxt = ss_pkg::S_DRAIN;
        end
      end
      ss_pkg::S_DRAIN:  state_nxt = ss_pkg::S_SWAP_A;
      ss_pkg::S_SWAP_A: state_nxt = ss_pkg::S_SWAP_B;
      ss_pkg::S_SWAP_B: state_nxt = more_pass ? ss_pkg::S_SCAN : ss_pkg::S_OUT_RD;
      ss_pkg::S_OUT_RD: begin
        if (out_free) begin
          state_nxt = ss_pkg::S_OUT_CAP;
        end
      end
      ss_pkg::S_OUT_CAP: state_nxt = out_final ? ss_pkg::S_LOAD : ss_pkg::S_OUT_RD;
      default: state_nxt = ss_pkg::S_LOAD;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_stall     = state_r != ss_pkg::S_LOAD;
    ram_we       = 1'b0;
    ram_waddr    = count_r[IDX_W-1:0];
    ram_wdata    = in_data.sort_value;
    ram_re       = 1'b0;
    ram_raddr    = rd_idx_r;
    count_nxt    = count_r;
    dropped_nxt  = dropped_r;
    start_nxt    = start_r;
    rd_idx_nxt   = rd_idx_r;
    out_idx_nxt  = out_idx_r;
    rd_vld_nxt   = 1'b0;
    rd_tag_nxt   = rd_idx_r;
    out_vld_nxt  = out_vld_r && out_stall;
    out_data_nxt = out_data_r;
    case (state_r)
      ss_pkg::S_LOAD: begin
        if (in_xfer) begin
          if (count_r < CNT_MAX) begin
            ram_we = 1'b1;
          end else begin
            dropped_nxt = 1'b1;
          end
          count_nxt   = count_load;
          start_nxt   = '0;
          rd_idx_nxt  = '0;
          out_idx_nxt = '0;
        end
      end
      ss_pkg::S_SCAN: begin
        ram_re     = 1'b1;
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = rd_idx_r + IDX_W'(1);
      end
      ss_pkg::S_SWAP_A: begin
        ram_we    = 1'b1;
        ram_waddr = min_idx;
        ram_wdata = start_val;
      end
      ss_pkg::S_SWAP_B: begin
        ram_we      = 1'b1;
        ram_waddr   = start_r;
        ram_wdata   = min_val;
        start_nxt   = start_r + IDX_W'(1);
        rd_idx_nxt  = start_r + IDX_W'(1);
        out_idx_nxt = '0;
      end
      ss_pkg::S_OUT_RD: begin
        ram_raddr = out_idx_r;
        ram_re    = out_free;
      end
      ss_pkg::S_OUT_CAP: begin
        out_vld_nxt               = 1'b1;
        out_data_nxt.sorted_value = $signed(ram_rdata);
        out_data_nxt.last_out     = out_final;
        out_data_nxt.overflow     = dropped_r;
        out_idx_nxt               = out_idx_r + IDX_W'(1);
        if (out_final) begin
          count_nxt   = '0;
          dropped_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ss_pkg::S_LOAD;
      count_r   <= '0;
      dropped_r <= 1'b0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    start_r    <= start_nxt;
    rd_idx_r   <= rd_idx_nxt;
    out_idx_r  <= out_idx_nxt;
    rd_tag_r   <= rd_tag_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("fill count beyond capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("ram read and write in the same cycle");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ss_pkg::S_SCAN) |-> (rd_idx_r >= start_r) && (CNT_W'(rd_idx_r) < count_r))
    else $error("scan address outside the unsorted tail");

  a_set_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ss_pkg::S_OUT_CAP && out_final) |=>
      (state_r == ss_pkg::S_LOAD) && (count_r == '0) && out_valid && out_data.last_out)
    else $error("set not closed after final result");

endmodule
